// ===== src/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg: shared types, codes and character helpers for the tokenizer
//
// Holds the scan mode type, the token kind codes, the character codes the
// scanner looks for, the keyword table and the default counter widths.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Default counter widths for the top-level parameters.
  localparam int LINE_BITS_DEFAULT   = 16;
  localparam int COLUMN_BITS_DEFAULT = 16;
  localparam int LENGTH_BITS_DEFAULT = 8;

  // One input item can cause at most this many tokens.
  localparam int NUM_SLOTS = 3;

  // Scan modes. The pending modes run from MODE_NUMBER to MODE_PSLASH.
  typedef enum logic [3:0] {
    MODE_IDLE      = 4'd0,
    MODE_NUMBER    = 4'd1,
    MODE_IDENT     = 4'd2,
    MODE_PEQ       = 4'd3,
    MODE_PBANG     = 4'd4,
    MODE_PLT       = 4'd5,
    MODE_PGT       = 4'd6,
    MODE_PSLASH    = 4'd7,
    MODE_LINECMT   = 4'd8,
    MODE_BLOCK     = 4'd9,
    MODE_BLOCKSTAR = 4'd10,
    MODE_HALT      = 4'd11,
    MODE_DONE      = 4'd12
  } scan_mode_t;

  typedef logic [4:0] token_kind_t;

  // Token kind codes.
  localparam token_kind_t KIND_EOF    = 5'd0;
  localparam token_kind_t KIND_NUM    = 5'd1;
  localparam token_kind_t KIND_IDENT  = 5'd2;
  localparam token_kind_t KIND_INT    = 5'd3;  // first keyword; keyword k is KIND_INT + k
  localparam token_kind_t KIND_ASSIGN = 5'd11;
  localparam token_kind_t KIND_EQ     = 5'd12;
  localparam token_kind_t KIND_NOT    = 5'd13;
  localparam token_kind_t KIND_NE     = 5'd14;
  localparam token_kind_t KIND_LT     = 5'd15;
  localparam token_kind_t KIND_LE     = 5'd16;
  localparam token_kind_t KIND_GT     = 5'd17;
  localparam token_kind_t KIND_GE     = 5'd18;
  localparam token_kind_t KIND_PLUS   = 5'd19;
  localparam token_kind_t KIND_MINUS  = 5'd20;
  localparam token_kind_t KIND_STAR   = 5'd21;
  localparam token_kind_t KIND_SLASH  = 5'd22;
  localparam token_kind_t KIND_LBRACE = 5'd23;
  localparam token_kind_t KIND_RBRACE = 5'd24;
  localparam token_kind_t KIND_LPAREN = 5'd25;
  localparam token_kind_t KIND_RPAREN = 5'd26;
  localparam token_kind_t KIND_LBRACK = 5'd27;
  localparam token_kind_t KIND_RBRACK = 5'd28;
  localparam token_kind_t KIND_SEMI   = 5'd29;
  localparam token_kind_t KIND_COMMA  = 5'd30;
  localparam token_kind_t KIND_ERR    = 5'd31;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  // Kind of a one-character token; KIND_EOF means the byte is none of them.
  function automatic token_kind_t single_kind(input logic [7:0] c);
    token_kind_t k;
    case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_SEMI:   k = KIND_SEMI;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_EOF;
    endcase
    return k;
  endfunction

  // Keyword lengths: int void if else while return input output.
  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0:    n = 3'd3;
      3'd1:    n = 3'd4;
      3'd2:    n = 3'd2;
      3'd3:    n = 3'd4;
      3'd4:    n = 3'd5;
      3'd5:    n = 3'd6;
      3'd6:    n = 3'd5;
      default: n = 3'd6;
    endcase
    return n;
  endfunction

  // Keyword text, left-justified in six bytes.
  function automatic logic [47:0] kw_text(input logic [2:0] k);
    logic [47:0] t;
    case (k)
      3'd0:    t = {"int", 24'h0};
      3'd1:    t = {"void", 16'h0};
      3'd2:    t = {"if", 32'h0};
      3'd3:    t = {"else", 16'h0};
      3'd4:    t = {"while", 8'h0};
      3'd5:    t = "return";
      3'd6:    t = {"input", 8'h0};
      default: t = "output";
    endcase
    return t;
  endfunction

  // Character at a position of a keyword; positions from six on read as NUL.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [47:0] t;
    logic [7:0]  ch;
    t = kw_text(k);
    case (pos)
      3'd0:    ch = t[47:40];
      3'd1:    ch = t[39:32];
      3'd2:    ch = t[31:24];
      3'd3:    ch = t[23:16];
      3'd4:    ch = t[15:8];
      3'd5:    ch = t[7:0];
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Modes that hold a token which is still open.
  function automatic logic is_pending(input scan_mode_t m);
    return (m == MODE_NUMBER) || (m == MODE_IDENT) || (m == MODE_PEQ) ||
           (m == MODE_PBANG) || (m == MODE_PLT) || (m == MODE_PGT) ||
           (m == MODE_PSLASH);
  endfunction

  // Kind of a two-character operator whose first character set the mode.
  function automatic token_kind_t pair_kind(input scan_mode_t m);
    token_kind_t k;
    case (m)
      MODE_PEQ:   k = KIND_EQ;
      MODE_PBANG: k = KIND_NE;
      MODE_PLT:   k = KIND_LE;
      default:    k = KIND_GE;
    endcase
    return k;
  endfunction

endpackage

// ===== src/cst_scan.sv =====
// ----------------------------------------------------------------------------
// cst_scan: scan state and per-byte token decision
//
// Holds the scan mode, keyword flags and position counters. For each
// transferred item it works out, in one pass, up to three tokens: the open
// token that the byte closes, the byte's own token (or the open token that
// end of source flushes), and the end-of-input token.
// ----------------------------------------------------------------------------
module cst_scan #(
  parameter int LINE_BITS   = cst_pkg::LINE_BITS_DEFAULT,
  parameter int COLUMN_BITS = cst_pkg::COLUMN_BITS_DEFAULT,
  parameter int LENGTH_BITS = cst_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          accept,
  input  logic [7:0]                                    source_byte,
  input  logic                                          byte_valid,
  input  logic                                          end_of_source,
  output logic [cst_pkg::NUM_SLOTS-1:0]                 slot_mask,
  output logic [cst_pkg::NUM_SLOTS-1:0][4:0]            slot_kind,
  output logic [cst_pkg::NUM_SLOTS-1:0][LINE_BITS-1:0]  slot_line,
  output logic [cst_pkg::NUM_SLOTS-1:0][COLUMN_BITS-1:0] slot_column,
  output logic [cst_pkg::NUM_SLOTS-1:0][LENGTH_BITS-1:0] slot_length
);
  import cst_pkg::*;

  // Scan state.
  scan_mode_t             mode;
  logic [7:0]             kw_cand;
  logic [LINE_BITS-1:0]   line_cnt;
  logic [COLUMN_BITS-1:0] col_cnt;
  logic [COLUMN_BITS-1:0] tok_start;
  logic [LENGTH_BITS-1:0] char_cnt;

  // State after the byte has been scanned.
  scan_mode_t             mode_b;
  logic [7:0]             kw_cand_b;
  logic [LINE_BITS-1:0]   line_b;
  logic [COLUMN_BITS-1:0] col_b;
  logic [COLUMN_BITS-1:0] start_b;
  logic [LENGTH_BITS-1:0] cnt_b;

  // Tokens decided by the byte.
  logic                   flush_open;
  logic                   own_valid;
  token_kind_t            own_kind;
  logic [COLUMN_BITS-1:0] own_col;
  logic [LENGTH_BITS-1:0] own_len;

  // End-of-source decisions and next state.
  logic                   active;
  logic                   flush_end;
  logic                   eof_valid;
  scan_mode_t             mode_next;

  // Clears the flag of every keyword that does not have c at position pos.
  function automatic logic [7:0] kw_match(input logic [7:0] cand, input logic [7:0] c,
                                          input logic [LENGTH_BITS-1:0] pos);
    logic [7:0] r;
    r = cand;
    for (int k = 0; k < 8; k++) begin
      if ((pos >= LENGTH_BITS'(kw_len(3'(k)))) || (kw_char(3'(k), pos[2:0]) != c)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  // Kind of an identifier: the first keyword still matching at full length.
  function automatic token_kind_t ident_kind(input logic [7:0] cand,
                                             input logic [LENGTH_BITS-1:0] n);
    token_kind_t kind;
    kind = KIND_IDENT;
    for (int k = 7; k >= 0; k--) begin
      if (cand[k] && (n == LENGTH_BITS'(kw_len(3'(k))))) begin
        kind = KIND_INT + 5'(k);
      end
    end
    return kind;
  endfunction

  // Kind of the open token that a pending mode holds.
  function automatic token_kind_t open_kind(input scan_mode_t m, input logic [7:0] cand,
                                            input logic [LENGTH_BITS-1:0] n);
    token_kind_t kind;
    case (m)
      MODE_NUMBER: kind = KIND_NUM;
      MODE_IDENT:  kind = ident_kind(cand, n);
      MODE_PEQ:    kind = KIND_ASSIGN;
      MODE_PBANG:  kind = KIND_NOT;
      MODE_PLT:    kind = KIND_LT;
      MODE_PGT:    kind = KIND_GT;
      default:     kind = KIND_SLASH;
    endcase
    return kind;
  endfunction

  // Length of the open token: words carry a count, operators are one long.
  function automatic logic [LENGTH_BITS-1:0] open_len(input scan_mode_t m,
                                                      input logic [LENGTH_BITS-1:0] n);
    return ((m == MODE_NUMBER) || (m == MODE_IDENT)) ? n : LENGTH_BITS'(1);
  endfunction

  assign active = (mode != MODE_HALT) && (mode != MODE_DONE);

  // Byte scan: mode transition, counter step and tokens caused by the byte.
  always_comb begin
    logic rescan;
    logic step;
    rescan     = 1'b0;
    step       = 1'b0;
    mode_b     = mode;
    kw_cand_b  = kw_cand;
    line_b     = line_cnt;
    col_b      = col_cnt;
    start_b    = tok_start;
    cnt_b      = char_cnt;
    flush_open = 1'b0;
    own_valid  = 1'b0;
    own_kind   = KIND_EOF;
    own_col    = col_cnt;
    own_len    = LENGTH_BITS'(1);

    if (byte_valid) begin
      case (mode)
        MODE_NUMBER: begin
          if (is_digit(source_byte)) begin
            cnt_b = (char_cnt == '1) ? char_cnt : char_cnt + 1'b1;
            step  = 1'b1;
          end else begin
            flush_open = 1'b1;
            rescan     = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_word(source_byte)) begin
            kw_cand_b = kw_match(kw_cand, source_byte, char_cnt);
            cnt_b     = (char_cnt == '1) ? char_cnt : char_cnt + 1'b1;
            step      = 1'b1;
          end else begin
            flush_open = 1'b1;
            rescan     = 1'b1;
          end
        end
        MODE_PEQ, MODE_PBANG, MODE_PLT, MODE_PGT: begin
          if (source_byte == CH_EQ) begin
            own_valid = 1'b1;
            own_kind  = pair_kind(mode);
            own_col   = tok_start;
            own_len   = LENGTH_BITS'(2);
            mode_b    = MODE_IDLE;
            step      = 1'b1;
          end else begin
            flush_open = 1'b1;
            rescan     = 1'b1;
          end
        end
        MODE_PSLASH: begin
          if (source_byte == CH_SLASH) begin
            mode_b = MODE_LINECMT;
            step   = 1'b1;
          end else if (source_byte == CH_STAR) begin
            mode_b = MODE_BLOCK;
            step   = 1'b1;
          end else begin
            flush_open = 1'b1;
            rescan     = 1'b1;
          end
        end
        MODE_LINECMT: begin
          // A NUL inside a line comment is an unexpected character.
          if (source_byte == CH_NUL) begin
            own_valid = 1'b1;
            own_kind  = KIND_ERR;
            mode_b    = MODE_HALT;
          end else begin
            if (source_byte == CH_NL) begin
              mode_b = MODE_IDLE;
            end
            step = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (source_byte == CH_STAR) begin
            mode_b = MODE_BLOCKSTAR;
          end
          step = 1'b1;
        end
        MODE_BLOCKSTAR: begin
          if (source_byte == CH_SLASH) begin
            mode_b = MODE_IDLE;
          end else if (source_byte != CH_STAR) begin
            mode_b = MODE_BLOCK;
          end
          step = 1'b1;
        end
        MODE_IDLE: begin
          rescan = 1'b1;
        end
        default: begin
          // Halted or finished: the byte is ignored.
        end
      endcase

      // Byte seen from idle: start a token, skip it or flag an error.
      if (rescan) begin
        mode_b = MODE_IDLE;
        if (is_space(source_byte)) begin
          step = 1'b1;
        end else if (is_digit(source_byte)) begin
          mode_b    = MODE_NUMBER;
          start_b   = col_cnt;
          kw_cand_b = '1;
          cnt_b     = LENGTH_BITS'(1);
          step      = 1'b1;
        end else if (is_alpha(source_byte) || (source_byte == CH_UNDER)) begin
          mode_b    = MODE_IDENT;
          start_b   = col_cnt;
          kw_cand_b = kw_match(8'hFF, source_byte, '0);
          cnt_b     = LENGTH_BITS'(1);
          step      = 1'b1;
        end else begin
          start_b = col_cnt;
          case (source_byte)
            CH_EQ:    mode_b = MODE_PEQ;
            CH_BANG:  mode_b = MODE_PBANG;
            CH_LT:    mode_b = MODE_PLT;
            CH_GT:    mode_b = MODE_PGT;
            CH_SLASH: mode_b = MODE_PSLASH;
            default: begin
              own_valid = 1'b1;
              own_kind  = single_kind(source_byte);
              own_col   = col_cnt;
              if (single_kind(source_byte) == KIND_EOF) begin
                own_kind = KIND_ERR;
                mode_b   = MODE_HALT;
              end
            end
          endcase
          if (mode_b != MODE_HALT) begin
            step = 1'b1;
          end
        end
      end

      // Position counters move past the byte.
      if (step) begin
        if (source_byte == CH_NL) begin
          line_b = (line_cnt == '1) ? line_cnt : line_cnt + 1'b1;
          col_b  = COLUMN_BITS'(1);
        end else begin
          col_b = (col_cnt == '1) ? col_cnt : col_cnt + 1'b1;
        end
      end
    end
  end

  // Next state: end of source flushes the open token and finishes the run.
  always_comb begin
    flush_end = end_of_source && active && is_pending(mode_b);
    eof_valid = end_of_source && active && (mode_b != MODE_HALT);
    mode_next = eof_valid ? MODE_DONE : mode_b;
  end

  // Outputs: the three token slots in emission order.
  always_comb begin
    slot_mask = {eof_valid, own_valid | flush_end, flush_open};

    slot_kind[0]   = open_kind(mode, kw_cand, char_cnt);
    slot_line[0]   = line_cnt;
    slot_column[0] = tok_start;
    slot_length[0] = open_len(mode, char_cnt);

    // The byte's own token and an end-of-source flush never come together.
    if (own_valid) begin
      slot_kind[1]   = own_kind;
      slot_line[1]   = line_cnt;
      slot_column[1] = own_col;
      slot_length[1] = own_len;
    end else begin
      slot_kind[1]   = open_kind(mode_b, kw_cand_b, cnt_b);
      slot_line[1]   = line_b;
      slot_column[1] = start_b;
      slot_length[1] = open_len(mode_b, cnt_b);
    end

    slot_kind[2]   = KIND_EOF;
    slot_line[2]   = line_b;
    slot_column[2] = col_b;
    slot_length[2] = '0;
  end

  // State register, updated on every transferred item until the run halts or finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      kw_cand   <= 8'hFF;
      line_cnt  <= LINE_BITS'(1);
      col_cnt   <= COLUMN_BITS'(1);
      tok_start <= COLUMN_BITS'(1);
      char_cnt  <= '0;
    end else if (accept && active) begin
      mode      <= mode_next;
      kw_cand   <= kw_cand_b;
      line_cnt  <= line_b;
      col_cnt   <= col_b;
      tok_start <= start_b;
      char_cnt  <= cnt_b;
    end
  end

endmodule

// ===== src/cst_out.sv =====
// ----------------------------------------------------------------------------
// cst_out: result register and token sequencer
//
// Captures the token slots of one item and hands them out one per transfer,
// lowest slot first. A new group is captured when the register is empty or
// its last token leaves in the same cycle.
// ----------------------------------------------------------------------------
module cst_out #(
  parameter int LINE_BITS   = cst_pkg::LINE_BITS_DEFAULT,
  parameter int COLUMN_BITS = cst_pkg::COLUMN_BITS_DEFAULT,
  parameter int LENGTH_BITS = cst_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           load,
  input  logic [cst_pkg::NUM_SLOTS-1:0]                  slot_mask,
  input  logic [cst_pkg::NUM_SLOTS-1:0][4:0]             slot_kind,
  input  logic [cst_pkg::NUM_SLOTS-1:0][LINE_BITS-1:0]   slot_line,
  input  logic [cst_pkg::NUM_SLOTS-1:0][COLUMN_BITS-1:0] slot_column,
  input  logic [cst_pkg::NUM_SLOTS-1:0][LENGTH_BITS-1:0] slot_length,
  output logic                                           free,
  output logic                                           token_valid,
  input  logic                                           token_ready,
  output logic [4:0]                                     token_kind,
  output logic [LINE_BITS-1:0]                           token_line,
  output logic [COLUMN_BITS-1:0]                         token_column,
  output logic [LENGTH_BITS-1:0]                         token_length,
  output logic                                           last_of_run
);
  import cst_pkg::*;

  logic [NUM_SLOTS-1:0]                  mask;
  logic [NUM_SLOTS-1:0][4:0]             kind_q;
  logic [NUM_SLOTS-1:0][LINE_BITS-1:0]   line_q;
  logic [NUM_SLOTS-1:0][COLUMN_BITS-1:0] col_q;
  logic [NUM_SLOTS-1:0][LENGTH_BITS-1:0] len_q;
  logic [1:0]                            sel;
  logic                                  single;
  logic                                  take;

  // Lowest occupied slot goes out first.
  always_comb begin
    if (mask[0]) begin
      sel = 2'd0;
    end else if (mask[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  assign single       = (mask & (mask - 1'b1)) == '0;
  assign token_valid  = |mask;
  assign take         = token_valid && token_ready;
  assign free         = !token_valid || (take && single);
  assign last_of_run  = single;
  assign token_kind   = kind_q[sel];
  assign token_line   = line_q[sel];
  assign token_column = col_q[sel];
  assign token_length = len_q[sel];

  // Occupancy: a load replaces the group, a transfer clears one slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= slot_mask;
    end else if (take) begin
      mask[sel] <= 1'b0;
    end
  end

  // Token payload.
  always_ff @(posedge clk) begin
    if (load) begin
      kind_q <= slot_kind;
      line_q <= slot_line;
      col_q  <= slot_column;
      len_q  <= slot_length;
    end
  end

endmodule

// ===== src/c_subset_tokenizer.sv =====
// ----------------------------------------------------------------------------
// c_subset_tokenizer: streaming lexer for a small C-like language
//
// Takes source bytes and emits tokens with kind, start line, start column
// and length. Whitespace and comments are skipped.
// ----------------------------------------------------------------------------
// An item is taken in every cycle as long as each item causes at most one
// token and every token is taken as soon as it is offered; an item that
// causes n tokens (n is at most three) holds the input until its last
// token leaves, because the tokens leave the result register one per
// transfer, and a stalled token side holds the input for as long as it
// stalls. Each byte is scanned combinationally from the scan state into
// that result register, and the next item is taken in the same cycle that
// the last token of the previous one is transferred. After an unexpected
// character the block sends an error token and then drops all input until
// reset; after the end-of-input token it drops all input until reset too.
module c_subset_tokenizer #(
  parameter int LINE_BITS   = cst_pkg::LINE_BITS_DEFAULT,
  parameter int COLUMN_BITS = cst_pkg::COLUMN_BITS_DEFAULT,
  parameter int LENGTH_BITS = cst_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic [7:0]             source_byte,
  input  logic                   byte_valid,
  input  logic                   end_of_source,
  output logic                   token_valid,
  input  logic                   token_ready,
  output logic [4:0]             token_kind,
  output logic [LINE_BITS-1:0]   token_line,
  output logic [COLUMN_BITS-1:0] token_column,
  output logic [LENGTH_BITS-1:0] token_length,
  output logic                   last_of_run
);
  import cst_pkg::*;

  logic                                  accept;
  logic                                  free;
  logic [NUM_SLOTS-1:0]                  slot_mask;
  logic [NUM_SLOTS-1:0][4:0]             slot_kind;
  logic [NUM_SLOTS-1:0][LINE_BITS-1:0]   slot_line;
  logic [NUM_SLOTS-1:0][COLUMN_BITS-1:0] slot_column;
  logic [NUM_SLOTS-1:0][LENGTH_BITS-1:0] slot_length;

  // The input is ready whenever the result register can take a group.
  assign item_ready = free;
  assign accept     = item_valid && item_ready;

  cst_scan #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .source_byte   (source_byte),
    .byte_valid    (byte_valid),
    .end_of_source (end_of_source),
    .slot_mask     (slot_mask),
    .slot_kind     (slot_kind),
    .slot_line     (slot_line),
    .slot_column   (slot_column),
    .slot_length   (slot_length)
  );

  cst_out #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .slot_mask    (slot_mask),
    .slot_kind    (slot_kind),
    .slot_line    (slot_line),
    .slot_column  (slot_column),
    .slot_length  (slot_length),
    .free         (free),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .token_line   (token_line),
    .token_column (token_column),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the c_subset_tokenizer lexer
//
// Feeds one source stream through the valid/ready input channel and checks
// every token transfer against a behavioral lexer kept inside the bench.
// Covers all operators, plus randomly chosen keywords, numbers, identifiers,
// comments, ignored items and one randomly chosen way to end the source.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int RANDOM_ITEMS = 120;
  localparam int TAIL_CYCLES  = 20;
  localparam int REPORT_LIMIT = 10;

  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  typedef struct packed {
    token_kind_t kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  length;
    logic        last;
  } token_t;

  // Ports of the block.
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        item_valid    = 1'b0;
  logic [7:0]  source_byte   = 8'h00;
  logic        byte_valid    = 1'b0;
  logic        end_of_source = 1'b0;
  logic        token_ready   = 1'b0;
  logic        item_ready;
  logic        token_valid;
  logic [4:0]  token_kind;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [7:0]  token_length;
  logic        last_of_run;

  // Lexer state mirrored by the bench, at its reset values.
  scan_mode_t  lex_mode = MODE_IDLE;
  logic [7:0]  kw_hits  = 8'hFF;
  logic [15:0] cur_line = 16'd1;
  logic [15:0] cur_col  = 16'd1;
  logic [15:0] tok_col  = 16'd1;
  logic [7:0]  tok_len  = 8'd0;

  token_t awaited_tokens[$];
  int     made_now;
  int     fail_count = 0;
  int     fed_bytes  = 0;
  bit     steady     = 1'b0;

  c_subset_tokenizer uut (
    .clk, .rst, .item_valid, .item_ready, .source_byte, .byte_valid,
    .end_of_source, .token_valid, .token_ready, .token_kind, .token_line,
    .token_column, .token_length, .last_of_run
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral lexer
  // --------------------------------------------------------------------------

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] bump8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic bit digit_byte(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit alpha_byte(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic bit space_byte(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit word_byte(input logic [7:0] c);
    return alpha_byte(c) || digit_byte(c) || c == CH_UNDER;
  endfunction

  // Kind of a character that is always a token by itself, else KIND_EOF.
  function automatic token_kind_t plain_op_kind(input logic [7:0] c);
    case (c)
      CH_PLUS:   return KIND_PLUS;
      CH_MINUS:  return KIND_MINUS;
      CH_STAR:   return KIND_STAR;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_LBRACK: return KIND_LBRACK;
      CH_RBRACK: return KIND_RBRACK;
      CH_SEMI:   return KIND_SEMI;
      CH_COMMA:  return KIND_COMMA;
      default:   return KIND_EOF;
    endcase
  endfunction

  function automatic bit starts_token(input logic [7:0] c);
    return space_byte(c) || word_byte(c) || c == CH_EQ || c == CH_BANG ||
           c == CH_LT || c == CH_GT || c == CH_SLASH || plain_op_kind(c) != KIND_EOF;
  endfunction

  function automatic string keyword_word(input int k);
    case (k)
      0:       return "int";
      1:       return "void";
      2:       return "if";
      3:       return "else";
      4:       return "while";
      5:       return "return";
      6:       return "input";
      default: return "output";
    endcase
  endfunction

  function automatic void push_token(input token_kind_t kind, input logic [15:0] column,
                                     input logic [7:0] length);
    token_t t;
    t = {kind, cur_line, column, length, 1'b0};
    if (made_now < NUM_SLOTS) begin
      awaited_tokens.insert(awaited_tokens.size(), t);
      made_now++;
    end
  endfunction

  function automatic void advance(input logic [7:0] c);
    if (c == CH_NL) begin
      cur_line = bump16(cur_line);
      cur_col  = 16'd1;
    end else begin
      cur_col = bump16(cur_col);
    end
  endfunction

  // Drop every keyword whose character at the current position differs.
  function automatic void narrow_keywords(input logic [7:0] c);
    string w;
    for (int k = 0; k < 8; k++) begin
      w = keyword_word(k);
      if (tok_len >= w.len() || w[tok_len] != c) kw_hits[k] = 1'b0;
    end
  endfunction

  function automatic void open_word(input scan_mode_t m, input logic [7:0] c);
    lex_mode = m;
    tok_col  = cur_col;
    tok_len  = 8'd0;
    kw_hits  = 8'hFF;
    if (m == MODE_IDENT) narrow_keywords(c);
    tok_len = 8'd1;
  endfunction

  function automatic token_kind_t word_kind();
    string w;
    for (int k = 0; k < 8; k++) begin
      w = keyword_word(k);
      if (kw_hits[k] && tok_len == w.len()) return token_kind_t'(KIND_INT + k);
    end
    return KIND_IDENT;
  endfunction

  // Emit the token held open by a pending mode and go back to idle.
  function automatic void close_token();
    case (lex_mode)
      MODE_NUMBER: push_token(KIND_NUM, tok_col, tok_len);
      MODE_IDENT:  push_token(word_kind(), tok_col, tok_len);
      MODE_PEQ:    push_token(KIND_ASSIGN, tok_col, 8'd1);
      MODE_PBANG:  push_token(KIND_NOT, tok_col, 8'd1);
      MODE_PLT:    push_token(KIND_LT, tok_col, 8'd1);
      MODE_PGT:    push_token(KIND_GT, tok_col, 8'd1);
      MODE_PSLASH: push_token(KIND_SLASH, tok_col, 8'd1);
      default:     return;
    endcase
    lex_mode = MODE_IDLE;
  endfunction

  function automatic void raise_error();
    push_token(KIND_ERR, cur_col, 8'd1);
    lex_mode = MODE_HALT;
  endfunction

  function automatic void lex_idle(input logic [7:0] c);
    token_kind_t k;
    if (space_byte(c)) begin
      advance(c);
      return;
    end
    if (digit_byte(c)) begin
      open_word(MODE_NUMBER, c);
      advance(c);
      return;
    end
    if (alpha_byte(c) || c == CH_UNDER) begin
      open_word(MODE_IDENT, c);
      advance(c);
      return;
    end
    tok_col = cur_col;
    case (c)
      CH_EQ:    lex_mode = MODE_PEQ;
      CH_BANG:  lex_mode = MODE_PBANG;
      CH_LT:    lex_mode = MODE_PLT;
      CH_GT:    lex_mode = MODE_PGT;
      CH_SLASH: lex_mode = MODE_PSLASH;
      default: begin
        k = plain_op_kind(c);
        if (k == KIND_EOF) begin
          raise_error();
          return;
        end
        push_token(k, cur_col, 8'd1);
      end
    endcase
    advance(c);
  endfunction

  function automatic void lex_byte(input logic [7:0] c);
    case (lex_mode)
      MODE_NUMBER: begin
        if (digit_byte(c)) begin
          tok_len = bump8(tok_len);
          advance(c);
          return;
        end
        close_token();
      end
      MODE_IDENT: begin
        if (word_byte(c)) begin
          narrow_keywords(c);
          tok_len = bump8(tok_len);
          advance(c);
          return;
        end
        close_token();
      end
      MODE_PEQ, MODE_PBANG, MODE_PLT, MODE_PGT: begin
        if (c == CH_EQ) begin
          push_token((lex_mode == MODE_PEQ) ? KIND_EQ : (lex_mode == MODE_PBANG) ? KIND_NE :
                     (lex_mode == MODE_PLT) ? KIND_LE : KIND_GE, tok_col, 8'd2);
          lex_mode = MODE_IDLE;
          advance(c);
          return;
        end
        close_token();
      end
      MODE_PSLASH: begin
        if (c == CH_SLASH || c == CH_STAR) begin
          lex_mode = (c == CH_SLASH) ? MODE_LINECMT : MODE_BLOCK;
          advance(c);
          return;
        end
        close_token();
      end
      MODE_LINECMT: begin
        if (c == CH_NUL) begin
          raise_error();
          return;
        end
        if (c == CH_NL) lex_mode = MODE_IDLE;
        advance(c);
        return;
      end
      MODE_BLOCK: begin
        if (c == CH_STAR) lex_mode = MODE_BLOCKSTAR;
        advance(c);
        return;
      end
      MODE_BLOCKSTAR: begin
        if (c == CH_SLASH) lex_mode = MODE_IDLE;
        else if (c != CH_STAR) lex_mode = MODE_BLOCK;
        advance(c);
        return;
      end
      MODE_IDLE: ;
      default: return;
    endcase
    lex_idle(c);
  endfunction

  // Work out the tokens of one accepted item and queue them.
  function automatic void predict_item(input logic [7:0] b, input logic bv, input logic eos);
    token_t t;
    made_now = 0;
    if (lex_mode == MODE_HALT || lex_mode == MODE_DONE) return;
    if (bv) lex_byte(b);
    if (eos && lex_mode != MODE_HALT) begin
      close_token();
      push_token(KIND_EOF, cur_col, 8'd0);
      lex_mode = MODE_DONE;
    end
    if (made_now > 0) begin
      t = awaited_tokens[awaited_tokens.size() - 1];
      t.last = 1'b1;
      awaited_tokens[awaited_tokens.size() - 1] = t;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers and token checker
  // --------------------------------------------------------------------------

  function automatic int pick_gap();
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // Offer one item and wait for its transfer. Valid is left high on return,
  // so the next call either replaces the payload or lowers valid first.
  task automatic send_item(input logic [7:0] b, input logic bv, input logic eos);
    int gap;
    bit took;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid    <= 1'b1;
    source_byte   <= b;
    byte_valid    <= bv;
    end_of_source <= eos;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = item_ready;
      if (took) begin
        predict_item(b, bv, eos);
        if (bv) fed_bytes++;
      end
      @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, 1'b0);
  endtask

  // Hold the input idle until every queued token has been transferred.
  task automatic drain_tokens();
    item_valid <= 1'b0;
    while (awaited_tokens.size() != 0) @(posedge clk);
  endtask

  // Token sink: random stall before each transfer.
  initial begin : token_sink
    int stall;
    bit seen;
    wait (!rst);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        token_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      token_ready <= 1'b1;
      seen = 1'b0;
      while (!seen) begin
        @(negedge clk);
        seen = token_valid;
        @(posedge clk);
      end
    end
  end

  // Outputs are stable at the falling edge; a transfer seen here completes
  // at the next rising edge.
  always @(negedge clk) begin : token_check
    token_t got, want;
    if (!rst && token_valid && token_ready) begin
      got = {token_kind, token_line, token_column, token_length, last_of_run};
      if (awaited_tokens.size() == 0) begin
        note_failure($sformatf("unexpected token: kind %0d line %0d column %0d length %0d",
                               got.kind, got.line, got.column, got.length));
      end else begin
        want = awaited_tokens.pop_front();
        if (got.kind !== want.kind || got.line !== want.line ||
            got.column !== want.column || got.length !== want.length ||
            got.last !== want.last)
          note_failure($sformatf(
            "token mismatch: expected k%0d l%0d c%0d n%0d last%0d, got k%0d l%0d c%0d n%0d last%0d",
            want.kind, want.line, want.column, want.length, want.last,
            got.kind, got.line, got.column, got.length, got.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [7:0] word_char(input bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'(CH_LO_A + r);
    if (r < 52) return 8'(CH_UP_A + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'(CH_ZERO + r - 53);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0:       return CH_TAB;
      1:       return CH_NL;
      2:       return CH_VT;
      3:       return CH_FF;
      4:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // A slash is followed by a space so that it never opens a comment.
  function automatic string op_text(input int i);
    case (i)
      0:       return "=";
      1:       return "==";
      2:       return "!";
      3:       return "!=";
      4:       return "<";
      5:       return "<=";
      6:       return ">";
      7:       return ">=";
      8:       return "+";
      9:       return "-";
      10:      return "*";
      11:      return "/ ";
      12:      return "{";
      13:      return "}";
      14:      return "(";
      15:      return ")";
      16:      return "[";
      17:      return "]";
      18:      return ";";
      default: return ",";
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every operator, with each pending first character closed by another one.
  task automatic test_operator_pairs();
    send_text("==!=<=>==!<>/+-*{}()[];,");
    send_item(CH_NL, 1'b1, 1'b0);
  endtask

  // Items without a byte and without an end mark change nothing.
  task automatic test_ignored_items();
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
  endtask

  // Random but well-formed program text, with some noise between lexemes.
  task automatic test_random_program();
    int         base, pick, n, variant;
    string      w;
    logic [7:0] b, prev;
    base = fed_bytes;
    while (fed_bytes - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      pick = $urandom_range(0, 18);
      case (pick)
        0, 1, 2: begin
          // Keyword, sometimes lengthened or cut short into an identifier.
          w = keyword_word($urandom_range(0, 7));
          variant = $urandom_range(0, 3);
          n = (variant == 3) ? w.len() - 1 : w.len();
          for (int i = 0; i < n; i++) send_item(w[i], 1'b1, 1'b0);
          if (variant == 2) send_item(word_char(1'b0), 1'b1, 1'b0);
          if ($urandom_range(0, 1)) send_item(CH_SPACE, 1'b1, 1'b0);
        end
        3, 4: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) send_item(word_char(i == 0), 1'b1, 1'b0);
          if ($urandom_range(0, 1)) send_item(CH_SPACE, 1'b1, 1'b0);
        end
        5, 6: begin
          n = $urandom_range(1, 5);
          for (int i = 0; i < n; i++)
            send_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b1, 1'b0);
        end
        7, 8, 9, 10: send_text(op_text($urandom_range(0, 19)));
        11, 12, 13: begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) send_item(blank_char(), 1'b1, 1'b0);
        end
        14: begin
          // Block comment with arbitrary bytes that never close it early.
          send_text("/*");
          n = $urandom_range(0, 6);
          prev = CH_NUL;
          for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (prev == CH_STAR && b == CH_SLASH) b = CH_STAR;
            send_item(b, 1'b1, 1'b0);
            prev = b;
          end
          if ($urandom_range(0, 1)) send_text("**/");
          else send_text("*/");
        end
        15: begin
          // Line comment with any byte but NUL and newline.
          send_text("//");
          n = $urandom_range(0, 6);
          for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(1, 255));
            if (b == CH_NL) b = CH_SPACE;
            send_item(b, 1'b1, 1'b0);
          end
          send_item(CH_NL, 1'b1, 1'b0);
        end
        16, 17: send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        default: if ($urandom_range(0, 2) == 0) drain_tokens();
      endcase
    end
    steady = 1'b0;
  endtask

  // One way of ending the source, then items that must all be dropped.
  task automatic test_source_end();
    logic [7:0] b;
    int         n;
    case ($urandom_range(0, 5))
      0: begin
        // Pending identifier, own token and end of input from one item.
        send_text("ab");
        send_item(CH_PLUS, 1'b1, 1'b1);
      end
      1: begin
        send_text("42");
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      2: begin
        // Unterminated block comment runs into the end of input.
        send_text("/*");
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_SLASH) b = CH_STAR;
          send_item(b, 1'b1, 1'b0);
        end
        send_item(CH_LO_A, 1'b1, 1'b1);
      end
      3: begin
        send_item(CH_SPACE, 1'b1, 1'b0);
        do b = 8'($urandom_range(0, 255)); while (starts_token(b));
        send_item(b, 1'b1, 1'($urandom_range(0, 1)));
      end
      4: begin
        send_text("//");
        send_item(CH_NUL, 1'b1, 1'($urandom_range(0, 1)));
      end
      default: begin
        // Line comment closed by the end of input.
        send_text("//q");
        send_item(CH_LO_Z, 1'b1, 1'b1);
      end
    endcase
    repeat (3)
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_operator_pairs();
    test_ignored_items();
    drain_tokens();
    test_random_program();
    test_source_end();
    item_valid <= 1'b0;
    while (awaited_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[c_subset_tokenizer] OK");
    end else begin
      $display("[c_subset_tokenizer] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("[c_subset_tokenizer] ERROR");
    $finish;
  end

endmodule
